/* hdl/steq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer event queue package
// Field widths, operation codes, cell commands and the records that pass
// between the queue controller and the cells of the sorted chain.
// ----------------------------------------------------------------------------
package steq_pkg;

   localparam int OP_W    = 2;
   localparam int TIMER_W = 4;
   localparam int DELAY_W = 32;
   localparam int TIME_W  = 64;

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_ARM     = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

   // What a cell loads at the next clock edge.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT,
      CELL_TAKE_NEW
   } cell_cmd_type;

   // Contents of one cell of the chain.
   typedef struct packed {
      logic               valid;
      logic [TIME_W-1:0]  deadline;
      logic [TIMER_W-1:0] timer;
   } cell_data_type;

   // Command and broadcast operands sent to every cell.
   typedef struct packed {
      cell_cmd_type       cmd;
      logic [TIME_W-1:0]  key;
      logic [TIMER_W-1:0] id;
   } cell_ctrl_type;

   // Local compare results that a cell reports back.
   typedef struct packed {
      logic hit;
      logic later;
   } cell_status_type;

   localparam cell_data_type EMPTY_CELL = '{valid: 1'b0, deadline: '0, timer: '0};

endpackage

/* hdl/steq_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue operation per item.
// ----------------------------------------------------------------------------
interface steq_req_if;
   import steq_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [TIMER_W-1:0] timer_id;
   logic [DELAY_W-1:0] delay_cycles;

   modport source (output valid, output operation, output timer_id,
                   output delay_cycles, input ready);
   modport sink   (input valid, input operation, input timer_id,
                   input delay_cycles, output ready);
endinterface

/* hdl/steq_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item per request item.
// ----------------------------------------------------------------------------
interface steq_rsp_if;
   import steq_pkg::*;

   logic               valid;
   logic               ready;
   logic               fired;
   logic [TIMER_W-1:0] fired_id;
   logic [TIME_W-1:0]  time_now;
   logic               none_armed;

   modport source (output valid, output fired, output fired_id, output time_now,
                   output none_armed, input ready);
   modport sink   (input valid, input fired, input fired_id, input time_now,
                   input none_armed, output ready);
endinterface

/* hdl/steq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one armed timer, compares it against the broadcast key and id, and
// loads from its left neighbor, its right neighbor or the new entry.
// ----------------------------------------------------------------------------
module steq_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  steq_pkg::cell_ctrl_type  ctrl,
   input  steq_pkg::cell_data_type  left_data,
   input  steq_pkg::cell_data_type  right_data,
   output steq_pkg::cell_data_type  data,
   output steq_pkg::cell_status_type status
);
   import steq_pkg::*;

   cell_data_type data_ff;
   cell_data_type data_in;

   // Next contents as chosen by the controller.
   always_comb begin
      case (ctrl.cmd)
         CELL_TAKE_LEFT:  data_in = left_data;
         CELL_TAKE_RIGHT: data_in = right_data;
         CELL_TAKE_NEW: begin
            data_in.valid    = 1'b1;
            data_in.deadline = ctrl.key;
            data_in.timer    = ctrl.id;
         end
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= EMPTY_CELL;
      end else begin
         data_ff <= data_in;
      end
   end

   // An empty cell counts as later than any key, so the later flags form a
   // suffix of the chain.
   assign status.hit   = data_ff.valid && (data_ff.timer == ctrl.id);
   assign status.later = !data_ff.valid || (data_ff.deadline > ctrl.key);
   assign data         = data_ff;

endmodule

/* hdl/sorted_timer_event_queue.sv */
// ----------------------------------------------------------------------------
// Sorted timer event queue
// Sequence: after acceptance the removal pass runs; for cancel, advance and the
// unused code the result register loads at its end, and for an arm an
// insertion pass follows and the result register loads at the end of that.
// The block takes no new item until the last result is loaded. The cell
// chain moves one pass per cycle; a waiting result stalls only the final pass.
// Reset clears the counter and every cell at once; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic       clock,
   input  logic       reset,
   steq_req_if.sink   req_ch,
   steq_rsp_if.source rsp_ch
);
   import steq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT
   } state_type;

   state_type          state_ff;
   logic [OP_W-1:0]    op_ff;
   logic [TIMER_W-1:0] id_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [TIME_W-1:0]  key_ff;
   logic [TIME_W-1:0]  count_ff;
   logic [TIME_W-1:0]  count_in;

   logic               rsp_valid_ff;
   logic               rsp_fired_ff;
   logic [TIMER_W-1:0] rsp_fired_id_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic               rsp_empty_ff;

   cell_data_type      cell_q      [NUM_TIMERS];
   cell_ctrl_type      cell_ctrl   [NUM_TIMERS];
   cell_status_type    cell_status [NUM_TIMERS];

   logic [NUM_TIMERS-1:0] hit_vec;
   logic [NUM_TIMERS-1:0] after_vec;
   logic [NUM_TIMERS-1:0] later_vec;
   logic [NUM_TIMERS-1:0] later_prev;

   logic out_free;
   logic id_ok;
   logic remove_final;
   logic remove_go;
   logic insert_go;
   logic rsp_load;
   logic head_fires;
   logic empty_after_remove;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign id_ok        = (32'(id_ff) < NUM_TIMERS);
   assign remove_final = (op_ff != OP_ARM) || !id_ok;
   assign remove_go    = (state_ff == ST_REMOVE) && (!remove_final || out_free);
   assign insert_go    = (state_ff == ST_INSERT) && out_free;
   assign rsp_load     = (remove_go && remove_final) || insert_go;
   assign head_fires   = (op_ff == OP_ADVANCE) && cell_q[0].valid;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Removal marks: the cell holding the timer, or the head on an advance.
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (op_ff == OP_ADVANCE) begin
            hit_vec[i] = (i == 0) && cell_q[0].valid;
         end else begin
            hit_vec[i] = ((op_ff == OP_ARM) || (op_ff == OP_CANCEL)) && id_ok &&
                         cell_status[i].hit;
         end
         later_vec[i] = cell_status[i].later;
      end
   end

   // Every cell at or after the removed one shifts left; log-depth prefix OR.
   always_comb begin
      after_vec = hit_vec;
      for (int s = 1; s < NUM_TIMERS; s = s * 2) begin
         after_vec = after_vec | (after_vec << s);
      end
   end

   assign later_prev = {later_vec[NUM_TIMERS-2:0], 1'b0};

   // Per-cell commands for the removal and insertion passes.
   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         cell_ctrl[i].key = key_ff;
         cell_ctrl[i].id  = id_ff;
         cell_ctrl[i].cmd = CELL_HOLD;
         if (remove_go) begin
            if (after_vec[i]) begin
               cell_ctrl[i].cmd = CELL_TAKE_RIGHT;
            end
         end else if (insert_go && !cell_q[NUM_TIMERS-1].valid) begin
            if (later_vec[i] && !later_prev[i]) begin
               cell_ctrl[i].cmd = CELL_TAKE_NEW;
            end else if (later_vec[i]) begin
               cell_ctrl[i].cmd = CELL_TAKE_LEFT;
            end
         end
      end
   end

   // The chain of cells, each linked to both neighbors.
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      cell_data_type left_d;
      cell_data_type right_d;
      if (i == 0) begin : g_first
         assign left_d = EMPTY_CELL;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == NUM_TIMERS - 1) begin : g_last
         assign right_d = EMPTY_CELL;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end
      steq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_q[i]),
         .status     (cell_status[i])
      );
   end

   // Counter after the removal pass.
   always_comb begin
      count_in = count_ff;
      if (op_ff == OP_ADVANCE) begin
         if (cell_q[0].valid) begin
            count_in = cell_q[0].deadline;
         end else begin
            count_in = count_ff + 64'd1;
         end
      end
   end

   assign empty_after_remove = !(after_vec[0] ? cell_q[1].valid : cell_q[0].valid);

   // Sequencer, counter and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         // A new result replaces the one that leaves in the same cycle.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= req_ch.operation;
                  id_ff    <= req_ch.timer_id;
                  delay_ff <= req_ch.delay_cycles;
                  state_ff <= ST_REMOVE;
               end
            end
            ST_REMOVE: begin
               if (remove_go) begin
                  count_ff <= count_in;
                  key_ff   <= count_ff + 64'(delay_ff);
                  if (remove_final) begin
                     rsp_fired_ff    <= head_fires;
                     rsp_fired_id_ff <= head_fires ? cell_q[0].timer : '0;
                     rsp_time_ff     <= count_in;
                     rsp_empty_ff    <= empty_after_remove;
                     state_ff        <= ST_IDLE;
                  end else begin
                     state_ff <= ST_INSERT;
                  end
               end
            end
            ST_INSERT: begin
               if (insert_go) begin
                  rsp_fired_ff    <= 1'b0;
                  rsp_fired_id_ff <= '0;
                  rsp_time_ff     <= count_ff;
                  rsp_empty_ff    <= 1'b0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.fired      = rsp_fired_ff;
   assign rsp_ch.fired_id   = rsp_fired_id_ff;
   assign rsp_ch.time_now   = rsp_time_ff;
   assign rsp_ch.none_armed = rsp_empty_ff;

endmodule

/* dv/tb_sorted_timer_event_queue.sv */
// ----------------------------------------------------------------------------
// Sorted timer event queue testbench
// Feeds arm, cancel, advance and unused-code items through the request
// channel with random gaps and response stalls. A behavioral copy of the
// deadline-sorted chain predicts every result, and the response monitor
// checks each one in order, field by field.
// ----------------------------------------------------------------------------
module tb_sorted_timer_event_queue;
   import steq_pkg::*;

   localparam int NUM_TIMERS  = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1150;
   localparam int MAX_REPORTS = 40;
   localparam int DRAIN_POINT = 250;
   localparam int QUIET_LO    = 450;
   localparam int QUIET_HI    = 700;
   localparam int SETTLE_CYCLES = 10;

   // Code 3 is not an operation; the block only reports its state.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [TIMER_W-1:0] id;
      logic [DELAY_W-1:0] delay;
   } timer_op_type;

   typedef struct packed {
      logic               fired;
      logic [TIMER_W-1:0] fired_id;
      logic [TIME_W-1:0]  time_now;
      logic               none_armed;
   } timer_event_type;

   logic clock;
   logic reset;

   steq_req_if req_bus ();
   steq_rsp_if rsp_bus ();

   sorted_timer_event_queue #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   // Stimulus and scoreboard storage.
   timer_op_type    op_queue[$];
   timer_event_type expected_events[$];
   int              items_taken;
   int              error_cnt;
   int              cycle_cnt;
   bit              req_taken;

   // Behavioral copy of the sorted chain.
   logic [TIME_W-1:0]  chain_deadline[NUM_TIMERS];
   logic [TIMER_W-1:0] chain_timer[NUM_TIMERS];
   int                 chain_len;
   logic [TIME_W-1:0]  model_now;

   always #4 clock = ~clock;

   // Drop the cell at pos and close the gap.
   function automatic void chain_remove_at(int pos);
      if (pos >= chain_len)
         return;
      for (int i = pos; i + 1 < chain_len; i++) begin
         chain_deadline[i] = chain_deadline[i+1];
         chain_timer[i]    = chain_timer[i+1];
      end
      chain_deadline[chain_len-1] = '0;
      chain_timer[chain_len-1]    = '0;
      chain_len--;
   endfunction

   function automatic void chain_remove_timer(logic [TIMER_W-1:0] id);
      for (int i = 0; i < chain_len; i++) begin
         if (chain_timer[i] == id) begin
            chain_remove_at(i);
            return;
         end
      end
   endfunction

   // Insert after every cell whose deadline is not later than the new one.
   function automatic void chain_insert(logic [TIMER_W-1:0] id, logic [TIME_W-1:0] deadline);
      int pos;
      if (chain_len >= NUM_TIMERS)
         return;
      pos = chain_len;
      for (int i = 0; i < chain_len; i++) begin
         if (chain_deadline[i] > deadline) begin
            pos = i;
            break;
         end
      end
      for (int i = chain_len; i > pos; i--) begin
         chain_deadline[i] = chain_deadline[i-1];
         chain_timer[i]    = chain_timer[i-1];
      end
      chain_deadline[pos] = deadline;
      chain_timer[pos]    = id;
      chain_len++;
   endfunction

   // Apply one accepted item to the chain and return the result it causes.
   function automatic timer_event_type step_timer_chain(timer_op_type item);
      timer_event_type ev;
      ev = '0;
      case (item.op)
         OP_ARM: begin
            chain_remove_timer(item.id);
            chain_insert(item.id, model_now + TIME_W'(item.delay));
         end
         OP_CANCEL: begin
            chain_remove_timer(item.id);
         end
         OP_ADVANCE: begin
            if (chain_len != 0) begin
               model_now   = chain_deadline[0];
               ev.fired    = 1'b1;
               ev.fired_id = chain_timer[0];
               chain_remove_at(0);
            end else begin
               model_now = model_now + TIME_W'(1);
            end
         end
         default: begin
         end
      endcase
      ev.time_now   = model_now;
      ev.none_armed = (chain_len == 0);
      return ev;
   endfunction

   task automatic report_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
      error_cnt++;
      if (error_cnt <= MAX_REPORTS)
         $display("mismatch %0d at cycle %0d: %s got 'h%0h expected 'h%0h",
                  error_cnt, cycle_cnt, what, got, want);
   endtask

   // Each side stalls with a chance of about 11 in a hundred, except in a quiet window.
   function automatic bit roll_idle();
      if (items_taken >= QUIET_LO && items_taken < QUIET_HI)
         return 1'b0;
      return ($urandom_range(99) < 11);
   endfunction

   function automatic logic [DELAY_W-1:0] pick_delay();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         return DELAY_W'($urandom_range(7));
      else if (r < 70)
         return DELAY_W'($urandom_range(1000));
      else if (r < 90)
         return $urandom;
      else if (r < 95)
         return '1;
      return '0;
   endfunction

   // Random item; fill phases favor arms, drain phases favor advances.
   function automatic timer_op_type pick_random_op(bit filling);
      timer_op_type item;
      int r;
      r = $urandom_range(99);
      item.id    = TIMER_W'($urandom_range(NUM_TIMERS - 1));
      item.delay = pick_delay();
      if (r < (filling ? 60 : 25))
         item.op = OP_ARM;
      else if (r < (filling ? 75 : 40))
         item.op = OP_CANCEL;
      else if (r < 96)
         item.op = OP_ADVANCE;
      else
         item.op = OP_UNUSED;
      return item;
   endfunction

   function automatic void queue_op(logic [OP_W-1:0] op, logic [TIMER_W-1:0] id,
                                    logic [DELAY_W-1:0] delay);
      timer_op_type item;
      item.op    = op;
      item.id    = id;
      item.delay = delay;
      op_queue.push_back(item);
   endfunction

   // Request driver: holds an item until it is taken, then maybe idles.
   always @(negedge clock) begin : drive_requests
      logic         next_valid;
      timer_op_type next_item;
      bit           drain_hold;
      next_valid = req_bus.valid;
      next_item  = '{req_bus.operation, req_bus.timer_id, req_bus.delay_cycles};
      drain_hold = (items_taken == DRAIN_POINT) && (expected_events.size() != 0);
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         next_valid = 1'b0;
         if (op_queue.size() != 0 && !drain_hold && !roll_idle()) begin
            next_item  = op_queue.pop_front();
            next_valid = 1'b1;
         end
      end
      req_taken = 1'b0;
      req_bus.valid        <= next_valid;
      req_bus.operation    <= next_item.op;
      req_bus.timer_id     <= next_item.id;
      req_bus.delay_cycles <= next_item.delay;
      rsp_bus.ready        <= !reset && !roll_idle();
   end

   // Monitor: predict on request acceptance, check on result acceptance.
   always @(posedge clock) begin : watch_channels
      timer_op_type    item;
      timer_event_type want;
      cycle_cnt++;
      if (!reset && req_bus.valid && req_bus.ready) begin
         item = '{req_bus.operation, req_bus.timer_id, req_bus.delay_cycles};
         expected_events.push_back(step_timer_chain(item));
         items_taken++;
         req_taken = 1'b1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("result with no expectation, time_now", rsp_bus.time_now, '0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_bus.fired !== want.fired)
               report_mismatch("fired", TIME_W'(rsp_bus.fired), TIME_W'(want.fired));
            if (rsp_bus.fired_id !== want.fired_id)
               report_mismatch("fired_id", TIME_W'(rsp_bus.fired_id),
                               TIME_W'(want.fired_id));
            if (rsp_bus.time_now !== want.time_now)
               report_mismatch("time_now", rsp_bus.time_now, want.time_now);
            if (rsp_bus.none_armed !== want.none_armed)
               report_mismatch("none_armed", TIME_W'(rsp_bus.none_armed),
                               TIME_W'(want.none_armed));
         end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("** sorted_timer_event_queue: FAILED **");
         $finish;
      end
   end

   initial begin
      bit filling;
      clock     = 1'b0;
      reset     = 1'b1;
      req_taken = 1'b0;
      items_taken = 0;
      error_cnt   = 0;
      cycle_cnt   = 0;
      chain_len   = 0;
      model_now   = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         chain_deadline[i] = '0;
         chain_timer[i]    = '0;
      end
      req_bus.valid        = 1'b0;
      req_bus.operation    = OP_ARM;
      req_bus.timer_id     = '0;
      req_bus.delay_cycles = '0;
      rsp_bus.ready        = 1'b0;

      // Directed part: empty advance, unarmed cancel, the unused code, a full
      // chain with equal deadlines and extreme delays, a re-arm while full.
      queue_op(OP_ADVANCE, '0, '0);
      queue_op(OP_CANCEL, 4'd7, '0);
      queue_op(OP_UNUSED, '1, '1);
      queue_op(OP_ARM, 4'd0, '1);
      for (int i = 1; i < NUM_TIMERS - 1; i++)
         queue_op(OP_ARM, TIMER_W'(i), DELAY_W'(i % 3));
      queue_op(OP_ARM, 4'd15, '0);
      queue_op(OP_ARM, 4'd5, DELAY_W'(1));
      queue_op(OP_CANCEL, 4'd9, '0);
      queue_op(OP_ADVANCE, '0, '0);
      queue_op(OP_ADVANCE, '0, '0);

      // Random part in fill and drain phases, each picked at random every 90 items.
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 90 == 0)
            filling = 1'($urandom_range(1));
         op_queue.push_back(pick_random_op(filling));
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all items to be taken and every result to come back.
      while (op_queue.size() != 0 || req_bus.valid || expected_events.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_events.size() != 0)
         report_mismatch("results still expected", TIME_W'(expected_events.size()), '0);
      if (error_cnt == 0)
         $display("** sorted_timer_event_queue: PASSED **");
      else
         $display("** sorted_timer_event_queue: FAILED **");
      $finish;
   end

endmodule
